[design/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared types and codes for the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_ZERO_DEN = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture operands and run the entry checks
    logic mul;       // form the cross products
    logic sum;       // combine the products into numerator and denominator
    logic gcd_init;  // start the gcd on the magnitudes
    logic gcd_step;  // one binary gcd step
    logic div_init;  // start the two divisions by the gcd
    logic div_step;  // one quotient bit of both divisions
    logic finish;    // apply the sign and the final range checks
  } rau_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;       // an error status is already known
    logic zero_num;  // the numerator is zero, no reduction needed
    logic gcd_done;  // the gcd has converged
    logic div_done;  // the divisions have produced all quotient bits
  } rau_stat_t;

endpackage

[design/rau_ctrl.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences load, products, gcd and divisions, and raises the result strobe.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import rau_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_GCD  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_GCD;
      end
      S_GCD: begin
        if (stat.err || stat.zero_num) begin
          state_next = S_FIN;
        end else begin
          // The dividends do not depend on the gcd, so the divider is armed
          // together with the gcd; the divisor is only read once it converged.
          cmd.gcd_init = 1'b1;
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        // Gcd steps run first; once converged the divisions are started.
        if (!stat.gcd_done) begin
          cmd.gcd_step = 1'b1;
        end else if (!stat.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

endmodule

[design/rau_dp.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Operand checks, cross products, binary gcd and restoring divisions.
// ----------------------------------------------------------------------------
module rau_dp #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  rau_pkg::rau_cmd_t  cmd,
  input  logic [1:0]         operation,
  input  logic signed [31:0] left_num,
  input  logic signed [31:0] left_den,
  input  logic signed [31:0] right_num,
  input  logic signed [31:0] right_den,
  output rau_pkg::rau_stat_t stat,
  output logic signed [31:0] result_num,
  output logic [30:0]        result_den,
  output logic [1:0]         status
);
  import rau_pkg::*;

  // Products need 2*WIDTH bits plus guard; magnitudes fit WIDTH bits.
  localparam int PW = 2 * WIDTH + 2;
  localparam int CW = $clog2(WIDTH + 1);
  localparam logic [WIDTH-1:0] LIM = {1'b1, {(WIDTH - 1){1'b0}}};

  logic [1:0]                op;
  logic signed [WIDTH:0]     a0, a1, b0, b1;  // operands after swap/negate
  logic signed [PW-1:0]      p0, p1, p2;
  logic signed [WIDTH+1:0]   num, den;
  logic [1:0]                st;
  logic [WIDTH-1:0]          mn, md, ga, gb;
  logic [CW-1:0]             shift, cnt;
  logic                      neg, gdone, ddone;
  logic [WIDTH-1:0]          qn, qd, rn, rd;

  function automatic logic fits(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] lo, hi;
    lo = -$signed({{(PW - WIDTH){1'b0}}, LIM});
    hi = $signed({{(PW - WIDTH){1'b0}}, LIM}) - 1;
    return (v >= lo) && (v <= hi);
  endfunction

  function automatic logic fits32(input logic signed [31:0] v);
    longint lo_v, hi_v;
    lo_v = -(64'sd1 <<< (WIDTH - 1));
    hi_v = (64'sd1 <<< (WIDTH - 1)) - 64'sd1;
    return (longint'(v) >= lo_v) && (longint'(v) <= hi_v);
  endfunction

  logic signed [PW-1:0] sum_w;
  logic [WIDTH-1:0]     mnum, mden;
  assign sum_w = p0 + p1;

  always_comb begin
    mnum = num[WIDTH+1] ? WIDTH'(-num) : WIDTH'(num);
    mden = den[WIDTH+1] ? WIDTH'(-den) : WIDTH'(den);
  end

  // Restoring division trial values.
  logic [WIDTH:0] tn, td;
  assign tn = {rn, qn[WIDTH-1]} - {1'b0, ga};
  assign td = {rd, qd[WIDTH-1]} - {1'b0, ga};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation;
      if (left_den == 0 || right_den == 0 || (operation == OP_DIV && right_num == 0)) begin
        st <= ST_ZERO_DEN;
      end else if (!fits32(left_num) || !fits32(left_den) || !fits32(right_num)
                   || !fits32(right_den)) begin
        st <= ST_OVERFLOW;
      end else if (operation == OP_SUB && right_num == $signed(-LIM)
                   && fits32(right_num)) begin
        st <= ST_OVERFLOW;
      end else begin
        st <= ST_OK;
      end
      a0 <= (WIDTH + 1)'(left_num);
      a1 <= (WIDTH + 1)'(left_den);
      b0 <= (operation == OP_SUB) ? -(WIDTH + 1)'(right_num)
          : (operation == OP_DIV) ? (WIDTH + 1)'(right_den) : (WIDTH + 1)'(right_num);
      b1 <= (operation == OP_DIV) ? (WIDTH + 1)'(right_num) : (WIDTH + 1)'(right_den);
    end
    if (cmd.mul) begin
      if (op == OP_ADD || op == OP_SUB) begin
        p0 <= PW'(a0 * b1);
        p1 <= PW'(b0 * a1);
      end else begin
        p0 <= PW'(a0 * b0);
        p1 <= '0;
      end
      p2 <= PW'(a1 * b1);
    end
    if (cmd.sum) begin
      if (st == ST_OK) begin
        if (op == OP_ADD || op == OP_SUB) begin
          if (!fits(p0) || !fits(p1) || !fits(sum_w) || !fits(p2)) st <= ST_OVERFLOW;
        end else if (!fits(p0) || !fits(p2)) begin
          st <= ST_OVERFLOW;
        end
      end
      num <= (WIDTH + 2)'(sum_w);
      den <= (WIDTH + 2)'(p2);
    end
    if (cmd.gcd_init) begin
      mn    <= mnum;
      md    <= mden;
      ga    <= mnum;
      gb    <= mden;
      shift <= '0;
      neg   <= num[WIDTH+1] ^ den[WIDTH+1];
      gdone <= 1'b0;
      ddone <= 1'b0;
    end
    if (cmd.gcd_step) begin
      // Binary gcd: strip common twos, then subtract the smaller odd value.
      if (ga == gb) begin
        ga    <= ga << shift;
        gdone <= 1'b1;
      end else if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1; gb <= gb >> 1; shift <= shift + 1'b1;
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga > gb) begin
        ga <= (ga - gb) >> 1;
      end else begin
        gb <= (gb - ga) >> 1;
      end
    end
    if (cmd.div_init) begin
      qn  <= mnum; qd <= mden; rn <= '0; rd <= '0;
      cnt <= CW'(WIDTH);
    end
    if (cmd.div_step) begin
      if (!tn[WIDTH]) rn <= tn[WIDTH-1:0]; else rn <= {rn[WIDTH-2:0], qn[WIDTH-1]};
      if (!td[WIDTH]) rd <= td[WIDTH-1:0]; else rd <= {rd[WIDTH-2:0], qd[WIDTH-1]};
      qn  <= {qn[WIDTH-2:0], !tn[WIDTH]};
      qd  <= {qd[WIDTH-2:0], !td[WIDTH]};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) ddone <= 1'b1;
    end
    if (cmd.finish) begin
      if (st != ST_OK || num == 0) begin
        status     <= st;
        result_num <= '0;
        result_den <= 31'd1;
      end else if (qd == LIM || (!neg && qn == LIM)) begin
        status     <= ST_OVERFLOW;
        result_num <= '0;
        result_den <= 31'd1;
      end else begin
        status     <= ST_OK;
        result_num <= neg ? -32'(qn) : 32'(qn);
        result_den <= 31'(qd);
      end
    end
  end

  assign stat.err      = (st != ST_OK);
  assign stat.zero_num = (num == 0);
  assign stat.gcd_done = gdone;
  assign stat.div_done = ddone;

endmodule

[design/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result by the gcd of its magnitudes.
// ----------------------------------------------------------------------------
// Channel   Handshake        Words
// input     start / busy     operation, left_num, left_den, right_num, right_den
// result    done strobe      result_num, result_den, status
//
// A word is taken when start is high and busy is low. The unit then stays
// busy while it runs the binary gcd steps and then the quotient bits of the two
// WIDTH-bit restoring dividers that run side by side. Error or zero numerator
// cases skip both loops and go straight to the final range checks and done.
// The result is shown for one cycle with done high; the receiver cannot
// stall it. Reset returns the controller to idle.
module rational_arithmetic_unit #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic signed [31:0] left_num,
  input  logic signed [31:0] left_den,
  input  logic signed [31:0] right_num,
  input  logic signed [31:0] right_den,
  output logic               done,
  output logic signed [31:0] result_num,
  output logic [30:0]        result_den,
  output logic [1:0]         status
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;

  // The controller sequences the datapath through its phases.
  rau_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  rau_dp #(.WIDTH(WIDTH)) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .operation (operation),
    .left_num  (left_num),
    .left_den  (left_den),
    .right_num (right_num),
    .right_den (right_den),
    .stat      (stat),
    .result_num(result_num),
    .result_den(result_den),
    .status    (status)
  );

endmodule
